// ===== src/mtp_pkg.sv =====
package mtp_pkg;

  localparam int WordW = 32;
  localparam int ValW  = 31;
  localparam int IdxW  = 10;

  localparam logic [WordW-1:0] TwistMatrix = 32'h9908b0df;
  localparam logic [WordW-1:0] TemperB     = 32'h9d2c5680;
  localparam logic [WordW-1:0] TemperC     = 32'hefc60000;
  localparam logic [WordW-1:0] SeedMult    = 32'd69069;
  localparam logic [WordW-1:0] SeedReset   = 32'd1965;

  typedef enum logic {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ValW-1:0] modulus;
  } cmd_t;

  function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] x);
    logic [WordW-1:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== src/mtp_cmd_fifo.sv =====
module mtp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mtp_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output mtp_pkg::cmd_t out_cmd
);
  import mtp_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'((in_valid && in_ready) ? 1 : 0)
                     - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

endmodule

// ===== src/mtp_engine.sv =====
module mtp_engine #(
  parameter int STATE_WORDS = 624,
  parameter int TAP_OFFSET  = 397
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              seed_value,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  mtp_pkg::cmd_t            cmd,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [mtp_pkg::ValW-1:0] res_value
);
  import mtp_pkg::*;

  localparam int AW = $clog2(STATE_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_GEN_A, S_GEN_B, S_GEN_C, S_GEN_W,
    S_READ, S_READ_W, S_DIV, S_OUT
  } state_t;

  state_t           state;
  logic [WordW-1:0] mem [STATE_WORDS];
  logic [WordW-1:0] rdata;
  logic [AW-1:0]    raddr;
  logic             wen;
  logic [AW-1:0]    waddr;
  logic [WordW-1:0] wdata;
  logic [AW-1:0]    k;
  logic [IdxW-1:0]  word_index;
  logic             seeded;
  logic [WordW-1:0] seed_word;
  logic [WordW-1:0] cur_k;
  logic [WordW-1:0] cur_n;
  logic [ValW-1:0]  modulus;
  logic [ValW-1:0]  quot;
  logic [ValW:0]    rem;
  logic [5:0]       bit_cnt;
  logic [WordW-1:0] y_mix;
  logic [WordW-1:0] twisted;
  logic [WordW-1:0] tempered;
  logic [ValW:0]    rem_sh;
  logic [AW-1:0]    k_nxt;
  logic [AW-1:0]    k_tap;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    k_nxt = (k == AW'(STATE_WORDS - 1)) ? '0 : k + AW'(1);
    k_tap = (k >= AW'(STATE_WORDS - TAP_OFFSET)) ? k - AW'(STATE_WORDS - TAP_OFFSET)
                                                 : k + AW'(TAP_OFFSET);
    y_mix    = {cur_k[31], cur_n[30:0]};
    twisted  = rdata ^ (y_mix >> 1) ^ (y_mix[0] ? TwistMatrix : '0);
    tempered = temper(rdata);
    rem_sh   = {rem[ValW-1:0], quot[ValW-1]};
    wen   = 1'b0;
    waddr = k;
    wdata = twisted;
    raddr = k;
    case (state)
      S_SEED: begin
        wen   = 1'b1;
        wdata = seed_word;
      end
      S_GEN_B: raddr = k_nxt;
      S_GEN_C: raddr = k_tap;
      S_GEN_W: wen = 1'b1;
      S_READ:  raddr = word_index[AW-1:0];
      default: ;
    endcase
  end

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_index <= IdxW'(STATE_WORDS);
      seeded     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (cmd_valid) begin
          modulus <= cmd.modulus;
          if (cmd.op == OP_RESEED || !seeded) begin
            seed_word <= seed_value;
            k         <= '0;
            seeded    <= 1'b1;
            state     <= (cmd.op == OP_RESEED) ? S_SEED : S_SEED;
            word_index <= (cmd.op == OP_RESEED) ? IdxW'(STATE_WORDS) : IdxW'(STATE_WORDS + 1);
          end else if (word_index == IdxW'(STATE_WORDS)) begin
            k     <= '0;
            state <= S_GEN_A;
          end else begin
            state <= S_READ;
          end
        end
        S_SEED: begin
          seed_word <= seed_word * SeedMult;
          if (k == AW'(STATE_WORDS - 1)) begin
            k <= '0;
            if (word_index == IdxW'(STATE_WORDS + 1)) begin
              word_index <= IdxW'(STATE_WORDS);
              state <= S_GEN_A;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            k <= k + AW'(1);
          end
        end
        S_GEN_A: state <= S_GEN_B;
        S_GEN_B: begin
          cur_k <= rdata;
          state <= S_GEN_C;
        end
        S_GEN_C: begin
          cur_n <= rdata;
          state <= S_GEN_W;
        end
        S_GEN_W: begin
          if (k == AW'(STATE_WORDS - 1)) begin
            word_index <= '0;
            state      <= S_READ;
          end else begin
            k     <= k + AW'(1);
            state <= S_GEN_A;
          end
        end
        S_READ: begin
          word_index <= word_index + IdxW'(1);
          state      <= S_READ_W;
        end
        S_READ_W: begin
          quot    <= tempered[ValW-1:0];
          rem     <= '0;
          bit_cnt <= '0;
          state   <= (modulus == '0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, modulus}) begin
            rem <= rem_sh - {1'b0, modulus};
          end else begin
            rem <= rem_sh;
          end
          quot    <= quot << 1;
          bit_cnt <= bit_cnt + 6'd1;
          if (bit_cnt == 6'(ValW - 1)) state <= S_OUT;
        end
        S_OUT: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_value = (modulus == '0) ? quot : rem[ValW-1:0];

endmodule

// ===== src/mersenne_twister_prng.sv =====
// A draw: read (S_READ, S_READ_W), 31 remainder steps if modulus is nonzero, output.
// The engine takes no new draw until its result is accepted; the command FIFO holds two;
// every 624th draw adds regeneration (S_GEN_A/B/C/W per word, one RAM port).
// Reseed writes the state in S_SEED, one state word written per cycle.
// Reset (rst, synchronous): seed register to 1965, state marked never seeded.
module mersenne_twister_prng #(
  parameter int STATE_WORDS = 624
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // modulus[30:0], zero
  input  logic        s_tuser,  // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // random_value[30:0], zero
);
  import mtp_pkg::*;

  logic [31:0]     seed_value;
  cmd_t            in_cmd;
  cmd_t            q_cmd;
  logic            q_valid;
  logic            q_ready;
  logic [ValW-1:0] res_value;

  always_ff @(posedge clk) begin
    if (rst) seed_value <= SeedReset;
    else if (cfg_we) seed_value <= cfg_wdata;
  end

  assign in_cmd = '{op: op_t'(s_tuser), modulus: s_tdata[ValW-1:0]};

  mtp_cmd_fifo u_fifo (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  mtp_engine #(.STATE_WORDS(STATE_WORDS)) u_engine (
    .clk, .rst, .seed_value,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(m_tvalid), .res_ready(m_tready), .res_value(res_value)
  );

  assign m_tdata = {1'b0, res_value};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !q_ready)
    else $error("engine took a command while a result waits");

endmodule
